@@ rtl/core/ttib_pkg.sv @@
// Shared types, constants and helper functions for the text-to-integer converter.
package ttib_pkg;

    localparam int MAX_DIGITS_DEF = 16;
    localparam int CHAR_W         = 8;
    localparam int NUM_W          = 32;
    localparam int LEN_W          = 5;
    localparam int DIGIT_W        = 4;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int ALPHA_SLOTS    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CHARS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 2'd2;

    localparam logic [CFG_W-1:0] RST_LOW_CHARS  = 64'h3736353433323130;
    localparam logic [CFG_W-1:0] RST_HIGH_CHARS = 64'h4645444342413938;
    localparam logic [LEN_W-1:0] RST_LENGTH     = 5'd10;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    typedef struct packed {
        logic               found;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

endpackage

@@ rtl/core/ttib_alpha.sv @@
// Digit alphabet registers, alphabet validation and parallel digit lookup.
module ttib_alpha #(
    parameter int MAX_DIGITS = ttib_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ttib_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttib_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [ttib_pkg::CHAR_W-1:0]     i_char,
    output ttib_pkg::t_digit                o_digit,
    output logic [ttib_pkg::LEN_W-1:0]      o_len,
    output logic                            o_alpha_ok
);

    logic [ttib_pkg::CFG_W-1:0]  r_low;
    logic [ttib_pkg::CFG_W-1:0]  r_high;
    logic [ttib_pkg::LEN_W-1:0]  r_len;
    logic                        r_ok;
    logic                        n_ok;
    logic [ttib_pkg::LEN_W-1:0]  w_lk_len;
    logic [ttib_pkg::CHAR_W-1:0] w_chars [ttib_pkg::ALPHA_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= ttib_pkg::RST_LOW_CHARS;
            r_high <= ttib_pkg::RST_HIGH_CHARS;
            r_len  <= ttib_pkg::RST_LENGTH;
            r_ok   <= 1'b1;
        end else begin
            r_ok <= n_ok;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ttib_pkg::CFG_LOW_CHARS:  r_low  <= i_cfg_data;
                    ttib_pkg::CFG_HIGH_CHARS: r_high <= i_cfg_data;
                    ttib_pkg::CFG_LENGTH:     r_len  <= i_cfg_data[ttib_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_chars[k]     = r_low[k*8 +: 8];
            w_chars[k + 8] = r_high[k*8 +: 8];
        end
    end

    assign w_lk_len = (r_len > ttib_pkg::LEN_W'(MAX_DIGITS)) ?
                      ttib_pkg::LEN_W'(MAX_DIGITS) : r_len;

    always_comb begin
        o_digit = '0;
        for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
            if ((ttib_pkg::LEN_W'(k) < w_lk_len) && (w_chars[k] == i_char)
                && (i_char != ttib_pkg::CH_NUL)) begin
                o_digit.found = 1'b1;
                o_digit.value = ttib_pkg::DIGIT_W'(k);
            end
        end
    end

    always_comb begin
        n_ok = (r_len >= 5'd2) && (r_len <= ttib_pkg::LEN_W'(MAX_DIGITS));
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (ttib_pkg::LEN_W'(i) < r_len) begin
                if ((w_chars[i] == ttib_pkg::CH_NUL) || (w_chars[i] == ttib_pkg::CH_PLUS)
                    || (w_chars[i] == ttib_pkg::CH_MINUS) || ttib_pkg::is_space(w_chars[i])) begin
                    n_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_DIGITS; j++) begin
                    if ((ttib_pkg::LEN_W'(j) < r_len) && (w_chars[j] == w_chars[i])) begin
                        n_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign o_len      = r_len;
    assign o_alpha_ok = r_ok;

endmodule

@@ rtl/core/ttib_step.sv @@
// Parse state machine and multiply-accumulate for one character per cycle while i_go is set.
module ttib_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_go,
    input  logic [ttib_pkg::CHAR_W-1:0]        i_char,
    input  logic                               i_final,
    input  ttib_pkg::t_digit                   i_digit,
    input  logic [ttib_pkg::LEN_W-1:0]         i_len,
    output logic signed [ttib_pkg::NUM_W-1:0]  o_number
);

    logic [1:0]                   r_phase;
    logic                         r_minus;
    logic [ttib_pkg::NUM_W-1:0]   r_acc;
    logic [1:0]                   n_phase;
    logic                         n_minus;
    logic [ttib_pkg::NUM_W-1:0]   n_acc;
    logic [ttib_pkg::NUM_W-1:0]   w_scaled;
    logic [ttib_pkg::NUM_W-1:0]   w_dig;

    assign w_scaled = r_acc * {{(ttib_pkg::NUM_W-ttib_pkg::LEN_W){1'b0}}, i_len};
    assign w_dig    = {{(ttib_pkg::NUM_W-ttib_pkg::DIGIT_W){1'b0}}, i_digit.value};

    always_comb begin
        n_phase = r_phase;
        n_minus = r_minus;
        n_acc   = r_acc;
        if ((n_phase == ttib_pkg::PH_SPACE) && !ttib_pkg::is_space(i_char)) begin
            n_phase = ttib_pkg::PH_SIGN;
        end
        if (n_phase == ttib_pkg::PH_SIGN) begin
            if (i_char == ttib_pkg::CH_MINUS) begin
                n_minus = ~n_minus;
            end else if (i_char != ttib_pkg::CH_PLUS) begin
                n_phase = ttib_pkg::PH_DIGIT;
            end
        end
        if (n_phase == ttib_pkg::PH_DIGIT) begin
            if (!i_digit.found) begin
                n_phase = ttib_pkg::PH_DONE;
            end else if (n_minus) begin
                n_acc = w_scaled - w_dig;
            end else begin
                n_acc = w_scaled + w_dig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ttib_pkg::PH_SPACE;
            r_minus <= 1'b0;
            r_acc   <= '0;
        end else if (i_go) begin
            if (i_final) begin
                r_phase <= ttib_pkg::PH_SPACE;
                r_minus <= 1'b0;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_minus <= n_minus;
                r_acc   <= n_acc;
            end
        end
    end

    assign o_number = signed'(n_acc);

endmodule

@@ rtl/core/text_to_integer_custom_base_core.sv @@
// o_out_valid rises once the final character has passed the input register into the output register.
// Throughput: one character per cycle; the output register holds a result while
// the next characters keep flowing in, and stalls input only on a final character.
// The critical path is the digit lookup compare followed by a 32x5 multiply-add.
// Reset is synchronous and active low: it clears the parse state and both handshake
// stages and restores the default decimal alphabet at once.
module text_to_integer_custom_base_core #(
    parameter int MAX_DIGITS = ttib_pkg::MAX_DIGITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ttib_pkg::CHAR_W-1:0]        i_character,
    input  logic                               i_final_char,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ttib_pkg::NUM_W-1:0]  o_number,
    output logic                               o_alphabet_ok,
    input  logic                               i_cfg_we,
    input  logic [ttib_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ttib_pkg::CFG_W-1:0]         i_cfg_data
);

    logic                               r_in_valid;
    logic [ttib_pkg::CHAR_W-1:0]        r_in_char;
    logic                               r_in_final;
    logic                               r_out_valid;
    logic signed [ttib_pkg::NUM_W-1:0]  r_number;
    logic                               r_ok;
    logic                               w_go;
    ttib_pkg::t_digit                   w_digit;
    logic [ttib_pkg::LEN_W-1:0]         w_len;
    logic                               w_alpha_ok;
    logic signed [ttib_pkg::NUM_W-1:0]  w_number;

    assign w_go       = r_in_valid && (!r_in_final || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char  <= i_character;
            r_in_final <= i_final_char;
        end
    end

    ttib_alpha #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_alpha (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (r_in_char),
        .o_digit     (w_digit),
        .o_len       (w_len),
        .o_alpha_ok  (w_alpha_ok)
    );

    ttib_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_char   (r_in_char),
        .i_final  (r_in_final),
        .i_digit  (w_digit),
        .i_len    (w_len),
        .o_number (w_number)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_in_final) begin
            r_number <= w_alpha_ok ? w_number : '0;
            r_ok     <= w_alpha_ok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_number      = r_number;
    assign o_alphabet_ok = r_ok;

endmodule

@@ rtl/core/ttib_checker.sv @@
// Port-level assertions for the text-to-integer converter and their bind.
module ttib_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic [ttib_pkg::CHAR_W-1:0]        i_character,
    input  logic                               i_final_char,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [ttib_pkg::NUM_W-1:0]  o_number,
    input  logic                               o_alphabet_ok
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_number))
        else $error("Stalled result changed or dropped.");

    a_bad_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_alphabet_ok |-> o_number == '0)
        else $error("Invalid alphabet gave a nonzero number.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled while no result is pending.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_character) && $stable(i_final_char))
        else $error("Waiting input transfer changed or dropped.");

endmodule

bind text_to_integer_custom_base_core ttib_checker u_ttib_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_character   (i_character),
    .i_final_char  (i_final_char),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_number      (o_number),
    .o_alphabet_ok (o_alphabet_ok)
);

@@ tb/ttib_result_checker.sv @@
// Result checker for the text-to-integer converter: tracks the parse, predicts and compares.
module ttib_result_checker
    import ttib_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [CHAR_W-1:0]       i_character,
    input  logic                    i_final_char,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [NUM_W-1:0] i_number,
    input  logic                    i_alphabet_ok,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_result_count
);

    typedef struct packed {
        logic signed [NUM_W-1:0] number;
        logic                    alphabet_ok;
    } t_parsed;

    t_parsed          parsed_q[$];
    logic [CFG_W-1:0] low_chars;
    logic [CFG_W-1:0] high_chars;
    logic [LEN_W-1:0] radix;
    logic [1:0]       phase;
    logic             negate;
    logic [NUM_W-1:0] acc;
    int               fail_count   = 0;
    int               pending      = 0;
    int               result_count = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending;
    assign o_result_count = result_count;

    function automatic logic [CHAR_W-1:0] slot_char(input int k);
        logic [CFG_W-1:0] word;
        word = (k < 8) ? low_chars : high_chars;
        return word[(k % 8) * 8 +: 8];
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function automatic logic alphabet_valid();
        int               n;
        logic [CHAR_W-1:0] c;
        n = int'(radix);
        if (n < 2 || n > MAX_DIGITS_DEF) return 1'b0;
        for (int i = 0; i < n; i++) begin
            c = slot_char(i);
            if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS || is_blank(c)) return 1'b0;
            for (int j = i + 1; j < n; j++) begin
                if (slot_char(j) == c) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int digit_value(input logic [CHAR_W-1:0] c);
        int n;
        n = (int'(radix) > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(radix);
        if (c == CH_NUL) return -1;
        for (int k = 0; k < n; k++) begin
            if (slot_char(k) == c) return k;
        end
        return -1;
    endfunction

    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
        int      d;
        t_parsed r;
        if (phase == PH_SPACE && !is_blank(c)) phase = PH_SIGN;
        if (phase == PH_SIGN) begin
            if (c == CH_MINUS) negate = ~negate;
            else if (c != CH_PLUS) phase = PH_DIGIT;
        end
        if (phase == PH_DIGIT) begin
            d = digit_value(c);
            if (d < 0) begin
                phase = PH_DONE;
            end else begin
                acc = acc * 32'(radix);
                acc = negate ? acc - 32'(d) : acc + 32'(d);
            end
        end
        if (last) begin
            r.alphabet_ok = alphabet_valid();
            r.number      = r.alphabet_ok ? acc : '0;
            parsed_q.push_back(r);
            phase  = PH_SPACE;
            negate = 1'b0;
            acc    = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_parsed exp_r;
        if (!i_rst_n) begin
            low_chars  = RST_LOW_CHARS;
            high_chars = RST_HIGH_CHARS;
            radix      = RST_LENGTH;
            phase      = PH_SPACE;
            negate     = 1'b0;
            acc        = '0;
            parsed_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (parsed_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result %0d: number %0d ok %0b",
                                 result_count, i_number, i_alphabet_ok);
                end else begin
                    exp_r = parsed_q.pop_front();
                    if (exp_r.number !== i_number || exp_r.alphabet_ok !== i_alphabet_ok) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch at result %0d: expected %0d ok %0b, got %0d ok %0b",
                                     result_count, exp_r.number, exp_r.alphabet_ok,
                                     i_number, i_alphabet_ok);
                    end
                end
            end
            if (i_in_valid && i_in_ready) parse_char(i_character, i_final_char);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOW_CHARS: begin
                        low_chars = i_cfg_data;
                    end
                    CFG_HIGH_CHARS: begin
                        high_chars = i_cfg_data;
                    end
                    CFG_LENGTH: begin
                        radix = i_cfg_data[LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending = parsed_q.size();
    end

endmodule

@@ tb/tb_text_to_integer_custom_base_core.sv @@
// Testbench top for the text-to-integer converter: stimulus, alphabet setup and verdict.
module tb_text_to_integer_custom_base_core;
    import ttib_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic [CHAR_W-1:0]       i_character  = '0;
    logic                    i_final_char = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic signed [NUM_W-1:0] o_number;
    logic                    o_alphabet_ok;
    logic                    i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = '0;
    logic [CFG_W-1:0]        i_cfg_data   = '0;

    int fail_count;
    int result_pending;
    int result_count;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int chars_sent     = 0;
    int strings_sent   = 0;
    int settings_used  = 0;

    logic [CHAR_W-1:0] alpha[ALPHA_SLOTS];
    logic [LEN_W-1:0]  alpha_len;

    text_to_integer_custom_base_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_character   (i_character),
        .i_final_char  (i_final_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_number      (o_number),
        .o_alphabet_ok (o_alphabet_ok),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ttib_result_checker u_result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_character    (i_character),
        .i_final_char   (i_final_char),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_number       (o_number),
        .i_alphabet_ok  (o_alphabet_ok),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (result_pending),
        .o_result_count (result_count)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, result_pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_character  <= ch;
        i_final_char <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input logic [CHAR_W-1:0] chars[$], input logic closes);
        foreach (chars[k]) send_char(chars[k], closes && (k == chars.size() - 1));
        if (closes) strings_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (result_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic load_alphabet(input logic [CHAR_W-1:0] chars[ALPHA_SLOTS],
                                 input logic [LEN_W-1:0] len);
        logic [CFG_W-1:0] low_word;
        logic [CFG_W-1:0] high_word;
        for (int k = 0; k < 8; k++) begin
            low_word[k*8 +: 8]  = chars[k];
            high_word[k*8 +: 8] = chars[k+8];
        end
        drain();
        write_reg(CFG_LOW_CHARS, low_word);
        write_reg(CFG_HIGH_CHARS, high_word);
        write_reg(CFG_LENGTH, CFG_W'(len));
        alpha     = chars;
        alpha_len = len;
        settings_used++;
    endtask

    function automatic logic [CHAR_W-1:0] random_symbol();
        logic [CHAR_W-1:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == CH_NUL || c == CH_PLUS || c == CH_MINUS || c == CH_SPACE ||
                   (c >= CH_TAB && c <= CH_CR));
        return c;
    endfunction

    // Mostly valid alphabets of random symbols, with one fault injected now and then.
    task automatic random_alphabet();
        logic [CHAR_W-1:0] chars[ALPHA_SLOTS];
        logic [LEN_W-1:0]  len;
        logic              clash;
        int                pick;
        int                i;
        int                j;
        pick = $urandom_range(7);
        if (pick == 0) len = 5'd2;
        else if (pick == 1) len = 5'd16;
        else len = 5'($urandom_range(3, 15));
        for (int k = 0; k < ALPHA_SLOTS; k++) begin
            do begin
                chars[k] = random_symbol();
                clash = 1'b0;
                for (int m = 0; m < k; m++) clash |= (chars[m] == chars[k]);
            end while (clash);
        end
        case ($urandom_range(11))
            0: begin
                len = 5'($urandom_range(1));
            end
            1: begin
                len = 5'($urandom_range(17, 31));
            end
            2: begin
                i = $urandom_range(int'(len) - 1);
                case ($urandom_range(4))
                    0: chars[i] = CH_NUL;
                    1: chars[i] = CH_PLUS;
                    2: chars[i] = CH_MINUS;
                    3: chars[i] = CH_SPACE;
                    default: chars[i] = 8'($urandom_range(9, 13));
                endcase
            end
            3: begin
                i = $urandom_range(int'(len) - 1);
                j = (i + 1 + $urandom_range(int'(len) - 2)) % int'(len);
                chars[j] = chars[i];
            end
            default: begin
            end
        endcase
        load_alphabet(chars, len);
    endtask

    // Well-formed numbers with random content most of the time, raw byte noise otherwise.
    task automatic send_random_string();
        logic [CHAR_W-1:0] text[$];
        int                span;
        int                n_digits;
        span = (alpha_len > 5'd16) ? 16 : int'(alpha_len);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(2))
                text.push_back(($urandom_range(5) == 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
            repeat ($urandom_range(3))
                text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            n_digits = ($urandom_range(5) == 0) ? $urandom_range(8, 14) : $urandom_range(6);
            repeat (n_digits)
                text.push_back((span == 0) ? 8'($urandom_range(255)) : alpha[$urandom_range(span - 1)]);
            repeat ($urandom_range(2)) text.push_back(8'($urandom_range(255)));
            if (text.size() == 0) text.push_back(8'($urandom_range(255)));
        end
        send_text(text, 1'b1);
        if ($urandom_range(39) == 0) drain();
    endtask

    initial begin
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] edge_chars[ALPHA_SLOTS];
        int                start_chars;
        for (int k = 0; k < 8; k++) begin
            alpha[k]   = RST_LOW_CHARS[k*8 +: 8];
            alpha[k+8] = RST_HIGH_CHARS[k*8 +: 8];
        end
        alpha_len = RST_LENGTH;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        text = '{CH_TAB, CH_CR, CH_SPACE, CH_MINUS, CH_PLUS, CH_MINUS, "4", "2", "x", "9"};
        send_text(text, 1'b1);
        text = '{CH_MINUS, "7"};
        send_text(text, 1'b1);
        text = '{8'hFF};
        send_text(text, 1'b1);
        text = '{CH_NUL, "5"};
        send_text(text, 1'b1);
        // The radix changes between the two digits of one string.
        text = '{"1"};
        send_text(text, 1'b0);
        load_alphabet(alpha, 5'd16);
        text = '{"F"};
        send_text(text, 1'b1);
        load_alphabet(alpha, 5'd1);
        text = '{"0"};
        send_text(text, 1'b1);
        load_alphabet(alpha, 5'd17);
        text = '{"3"};
        send_text(text, 1'b1);
        load_alphabet(alpha, 5'd0);
        text = '{CH_SPACE};
        send_text(text, 1'b1);
        for (int k = 0; k < ALPHA_SLOTS; k++) edge_chars[k] = (k < 8) ? 8'h00 : 8'hFF;
        load_alphabet(edge_chars, 5'd31);
        write_reg(CFG_UNUSED, '1);
        text = '{"0"};
        send_text(text, 1'b1);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase
            for (int s = 0; s < 4; s++) begin
                if (p == 0 && s == 0) begin
                    for (int k = 0; k < 8; k++) begin
                        edge_chars[k]   = RST_LOW_CHARS[k*8 +: 8];
                        edge_chars[k+8] = RST_HIGH_CHARS[k*8 +: 8];
                    end
                    load_alphabet(edge_chars, RST_LENGTH);
                end else if (p == 1 && s == 0) begin
                    load_alphabet(edge_chars, 5'd16);
                end else begin
                    random_alphabet();
                end
                start_chars = chars_sent;
                while (chars_sent - start_chars < 114) send_random_string();
            end
        end

        drain();
        $display("Covered %0d strings, %0d characters, %0d alphabet settings, four idle patterns.",
                 strings_sent, chars_sent, settings_used);
        $display("Compared %0d results, %0d mismatches.", result_count, fail_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
